>>> rtl/vcrle_pkg.sv
package vcrle_pkg;

  // Chunk class codes as they arrive with the first item of a chunk.
  localparam logic [1:0] CLASS_EMPTY   = 2'd0;
  localparam logic [1:0] CLASS_UNIFORM = 2'd1;
  localparam logic [1:0] CLASS_MIXED   = 2'd2;

  // Tag bytes that open a chunk's save stream.
  localparam logic [7:0] TAG_EMPTY   = 8'h00;
  localparam logic [7:0] TAG_UNIFORM = 8'h01;
  localparam logic [7:0] TAG_MIXED   = 8'h02;

  // Saturation value of a run count.
  localparam logic [15:0] RUN_MAX = 16'hffff;

  // Depth of the command queue between the front and the back.
  localparam int unsigned CMD_DEPTH = 4;
  localparam int unsigned CMD_PTR_W = $clog2(CMD_DEPTH);

  // One input item.
  typedef struct packed {
    logic [7:0] block_id;
    logic [1:0] chunk_class;
    logic       first_of_chunk;
    logic       last_of_chunk;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } out_item_t;

  // Bytes caused by one item: up to three leading bytes (tag, tag and id,
  // or a finished run), then optionally the closing run of a mixed chunk.
  typedef struct packed {
    logic [2:0][7:0] head_bytes;
    logic [1:0]      head_cnt;
    logic            tail_en;
    logic [15:0]     tail_len;
    logic [7:0]      tail_val;
  } cmd_t;

endpackage

>>> rtl/vcrle_front.sv
module vcrle_front import vcrle_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  in_item_t item_i,
  output logic     cmd_push_o,
  output cmd_t     cmd_o
);

  logic [7:0]  run_value_q, run_value_d;
  logic [15:0] run_length_q, run_length_d;
  logic [1:0]  class_q, class_d;

  // Classify the item, update the run state and collect the bytes it causes.
  always_comb begin
    run_value_d  = run_value_q;
    run_length_d = run_length_q;
    class_d      = class_q;
    cmd_o        = '0;
    if (item_i.first_of_chunk) begin
      class_d      = item_i.chunk_class;
      run_length_d = '0;
      case (item_i.chunk_class)
        CLASS_EMPTY: begin
          cmd_o.head_bytes[0] = TAG_EMPTY;
          cmd_o.head_cnt      = 2'd1;
        end
        CLASS_MIXED: begin
          cmd_o.head_bytes[0] = TAG_MIXED;
          cmd_o.head_cnt      = 2'd1;
          run_value_d         = item_i.block_id;
          run_length_d        = 16'd1;
        end
        default: begin
          cmd_o.head_bytes[0] = TAG_UNIFORM;
          cmd_o.head_bytes[1] = item_i.block_id;
          cmd_o.head_cnt      = 2'd2;
        end
      endcase
    end else if (class_q == CLASS_MIXED) begin
      if (run_length_q == '0) begin
        run_value_d  = item_i.block_id;
        run_length_d = 16'd1;
      end else if (item_i.block_id == run_value_q) begin
        if (run_length_q != RUN_MAX) begin
          run_length_d = run_length_q + 16'd1;
        end
      end else begin
        cmd_o.head_bytes[0] = run_length_q[7:0];
        cmd_o.head_bytes[1] = run_length_q[15:8];
        cmd_o.head_bytes[2] = run_value_q;
        cmd_o.head_cnt      = 2'd3;
        run_value_d         = item_i.block_id;
        run_length_d        = 16'd1;
      end
    end
    // The last item of a chunk closes the open run and ends the chunk.
    if (item_i.last_of_chunk) begin
      if (class_d == CLASS_MIXED && run_length_d != '0) begin
        cmd_o.tail_en  = 1'b1;
        cmd_o.tail_len = run_length_d;
        cmd_o.tail_val = run_value_d;
      end
      class_d      = CLASS_EMPTY;
      run_length_d = '0;
    end
  end

  // Only items that cause bytes enter the command queue.
  assign cmd_push_o = accept_i && (cmd_o.head_cnt != 2'd0 || cmd_o.tail_en);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_value_q  <= '0;
      run_length_q <= '0;
      class_q      <= CLASS_EMPTY;
    end else if (accept_i) begin
      run_value_q  <= run_value_d;
      run_length_q <= run_length_d;
      class_q      <= class_d;
    end
  end

endmodule

>>> rtl/vcrle_cmd_fifo.sv
module vcrle_cmd_fifo import vcrle_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t cmd_o
);

  cmd_t                 mem_q [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CMD_PTR_W:0]   count_q;
  logic                 do_push, do_pop;

  assign full_o  = (count_q == (CMD_PTR_W + 1)'(CMD_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = mem_q[rd_ptr_q];

  // Storage for queued commands.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

>>> rtl/vcrle_back.sv
module vcrle_back import vcrle_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_empty_i,
  input  cmd_t      cmd_i,
  output logic      cmd_pop_o,
  output logic      empty_o,
  input  logic      pop_i,
  output out_item_t result_o
);

  logic [2:0] idx_q, idx_d;
  logic [2:0] total;
  logic [2:0] tail_idx;
  logic       take;
  logic       at_end;

  // Number of bytes in the head command and position inside the closing run.
  assign total    = {1'b0, cmd_i.head_cnt} + (cmd_i.tail_en ? 3'd3 : 3'd0);
  assign tail_idx = idx_q - {1'b0, cmd_i.head_cnt};
  assign at_end   = (idx_q == total - 3'd1);
  assign empty_o  = cmd_empty_i;
  assign take     = pop_i && !cmd_empty_i;

  // Select the byte at the current position of the command.
  always_comb begin
    if (idx_q < {1'b0, cmd_i.head_cnt}) begin
      result_o.out_byte = cmd_i.head_bytes[idx_q[1:0]];
    end else begin
      case (tail_idx)
        3'd0:    result_o.out_byte = cmd_i.tail_len[7:0];
        3'd1:    result_o.out_byte = cmd_i.tail_len[15:8];
        default: result_o.out_byte = cmd_i.tail_val;
      endcase
    end
    result_o.last_byte = at_end;
  end

  // Step through the command, releasing it after its final byte.
  assign cmd_pop_o = take && at_end;

  always_comb begin
    idx_d = idx_q;
    if (take) begin
      idx_d = at_end ? 3'd0 : idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

>>> rtl/voxel_chunk_rle_encoder.sv
// Run-length encoder for voxel chunks. Feed the chunk's block ids in scan
// order with the chunk class and first and last marks; the block returns the
// chunk's save bytes (tag, then id or run records of a 16-bit count, low byte
// first, and the id), with last_byte set on the final byte each item causes.
// An item is accepted in every cycle in which the four-entry command queue
// has room, and its first byte can be taken in the next cycle. Bytes leave
// at one per cycle from the byte sequencer while pop holds, and an item
// causes zero to six bytes, so the sustained input rate is one item per cycle
// while items cause at most one byte each, otherwise the output byte rate.
module voxel_chunk_rle_encoder import vcrle_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  in_item_t  item_i,
  output logic      empty,
  input  logic      pop,
  output out_item_t result_o
);

  logic accept;
  logic cmd_push, cmd_pop, cmd_full, cmd_empty;
  cmd_t cmd_in, cmd_out;

  assign full   = cmd_full;
  assign accept = push && !cmd_full;

  vcrle_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .item_i     (item_i),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  vcrle_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .cmd_i   (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .empty_o (cmd_empty),
    .cmd_o   (cmd_out)
  );

  vcrle_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .result_o    (result_o)
  );

endmodule

>>> rtl/vcrle_checker.sv
module vcrle_checker import vcrle_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      push,
  input logic      full,
  input in_item_t  item_i,
  input logic      empty,
  input logic      pop,
  input out_item_t result_o
);

  // No bytes wait while reset is held.
  assert property (@(posedge clk_i) !rst_ni |-> empty)
    else $error("results shown during reset");

  // Bytes appear only after an item has been accepted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (empty && !(push && !full)) |=> empty)
    else $error("result without an accepted item");

  // An empty chunk opens with a single tag byte when nothing else waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (empty && push && !full && item_i.first_of_chunk &&
     item_i.chunk_class == CLASS_EMPTY)
    |=> (!empty && result_o.out_byte == TAG_EMPTY && result_o.last_byte))
    else $error("empty chunk tag wrong");

  // A waiting byte holds until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(result_o)))
    else $error("waiting result changed");

endmodule

bind voxel_chunk_rle_encoder vcrle_checker u_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .push     (push),
  .full     (full),
  .item_i   (item_i),
  .empty    (empty),
  .pop      (pop),
  .result_o (result_o)
);
